// ===== hw/rtl/gcr_telemetry_decoder_defines.svh =====
// ----------------------------------------------------------------------------
// gcr_telemetry_decoder_defines
// Assertion macros shared by the telemetry decoder RTL.
// ----------------------------------------------------------------------------
`ifndef GCR_TELEMETRY_DECODER_DEFINES_SVH
`define GCR_TELEMETRY_DECODER_DEFINES_SVH

// Same-cycle implication, sampled on i_clk, off during reset.
`define GCR_ASSERT_SAME(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("gcr assertion failed");

// Next-cycle implication, sampled on i_clk, off during reset.
`define GCR_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("gcr assertion failed");

`endif

// ===== hw/rtl/gcr_pkg.sv =====
// ----------------------------------------------------------------------------
// gcr_pkg
// Types, constants and the GCR symbol table for the telemetry decoder.
// ----------------------------------------------------------------------------
`default_nettype none

package gcr_pkg;

    localparam int WIRE_W   = 21;
    localparam int GCR_W    = 20;
    localparam int PAY_W    = 16;
    localparam int CODE_W   = 12;
    localparam int PER_W    = 16;
    localparam int QUO_W    = 26;
    localparam int DIV_CELLS = QUO_W;

    localparam logic [QUO_W-1:0] ERPM_NUM = 26'd60000000;

    typedef enum logic [1:0] {
        ST_OK          = 2'd0,
        ST_BAD_SYMBOL  = 2'd1,
        ST_CRC_FAIL    = 2'd2,
        ST_ZERO_PERIOD = 2'd3
    } t_status;

    // Word moving along the divider chain.
    typedef struct packed {
        t_status            status;
        logic [PAY_W-1:0]   payload;
        logic [CODE_W-1:0]  period_code;
        logic [PER_W-1:0]   period;
        logic [PER_W-1:0]   rem;
        logic [QUO_W-1:0]   quo;
    } t_div_word;

    // Inverse GCR: {valid, nibble}.
    function automatic logic [4:0] sym_to_nib(input logic [4:0] sym);
        logic [4:0] res;
        case (sym)
            5'h09: res = {1'b1, 4'h9};
            5'h0A: res = {1'b1, 4'hA};
            5'h0B: res = {1'b1, 4'hB};
            5'h0D: res = {1'b1, 4'hD};
            5'h0E: res = {1'b1, 4'hE};
            5'h0F: res = {1'b1, 4'hF};
            5'h12: res = {1'b1, 4'h2};
            5'h13: res = {1'b1, 4'h3};
            5'h15: res = {1'b1, 4'h5};
            5'h16: res = {1'b1, 4'h6};
            5'h17: res = {1'b1, 4'h7};
            5'h19: res = {1'b1, 4'h0};
            5'h1A: res = {1'b1, 4'h8};
            5'h1B: res = {1'b1, 4'h1};
            5'h1D: res = {1'b1, 4'h4};
            5'h1E: res = {1'b1, 4'hC};
            default: res = 5'h00;
        endcase
        return res;
    endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/gcr_front.sv =====
// ----------------------------------------------------------------------------
// gcr_front
// Decode stage: differential decode, inverse GCR, check, period expansion.
// ----------------------------------------------------------------------------
`default_nettype none

module gcr_front (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_valid,
    input  wire logic [gcr_pkg::WIRE_W-1:0]    i_wire_word,
    output logic                               o_ready,
    output logic                               o_valid,
    output gcr_pkg::t_div_word                 o_word,
    input  wire logic                          i_ready
);

    logic                       r_valid;
    gcr_pkg::t_div_word         r_word;
    gcr_pkg::t_div_word         n_word;

    logic [gcr_pkg::GCR_W-1:0]  gcr;
    logic [4:0]                 nib [4];
    logic                       sym_ok;
    logic [gcr_pkg::PAY_W-1:0]  pay;
    logic [3:0]                 chk;
    logic [gcr_pkg::CODE_W-1:0] code;
    logic [gcr_pkg::PER_W-1:0]  per;

    assign gcr = gcr_pkg::GCR_W'(i_wire_word ^ (i_wire_word >> 1));

    always_comb begin
        for (int k = 0; k < 4; k++) begin
            nib[k] = gcr_pkg::sym_to_nib(gcr[gcr_pkg::GCR_W-1-5*k -: 5]);
        end
        sym_ok = nib[0][4] & nib[1][4] & nib[2][4] & nib[3][4];
        pay    = {nib[0][3:0], nib[1][3:0], nib[2][3:0], nib[3][3:0]};
        chk    = nib[0][3:0] ^ nib[1][3:0] ^ nib[2][3:0] ^ nib[3][3:0];
        code   = pay[gcr_pkg::PAY_W-1 -: gcr_pkg::CODE_W];
        per    = gcr_pkg::PER_W'(code[8:0]) << code[11:9];

        n_word             = '0;
        if (!sym_ok) begin
            n_word.status = gcr_pkg::ST_BAD_SYMBOL;
        end else if (chk != 4'hF) begin
            n_word.status  = gcr_pkg::ST_CRC_FAIL;
            n_word.payload = pay;
        end else if (per == '0) begin
            n_word.status      = gcr_pkg::ST_ZERO_PERIOD;
            n_word.payload     = pay;
            n_word.period_code = code;
        end else begin
            n_word.status      = gcr_pkg::ST_OK;
            n_word.payload     = pay;
            n_word.period_code = code;
            n_word.period      = per;
        end
    end

    assign o_ready = !r_valid || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
        if (o_ready && i_valid) begin
            r_word <= n_word;
        end
    end

    assign o_valid = r_valid;
    assign o_word  = r_word;

endmodule

`default_nettype wire

// ===== hw/rtl/gcr_div_cell.sv =====
// ----------------------------------------------------------------------------
// gcr_div_cell
// One restoring-division step: one eRPM quotient bit per cell.
// ----------------------------------------------------------------------------
`default_nettype none

module gcr_div_cell (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_num_bit,
    input  wire logic                i_valid,
    input  wire gcr_pkg::t_div_word  i_word,
    output logic                     o_ready,
    output logic                     o_valid,
    output gcr_pkg::t_div_word       o_word,
    input  wire logic                i_ready
);

    logic                          r_valid;
    gcr_pkg::t_div_word            r_word;
    gcr_pkg::t_div_word            n_word;
    logic [gcr_pkg::PER_W:0]       trial;
    logic [gcr_pkg::PER_W:0]       diff;
    logic                          ge;

    // Shift in the next numerator bit, subtract the divisor if it fits.
    always_comb begin
        trial  = {i_word.rem, i_num_bit};
        diff   = trial - {1'b0, i_word.period};
        ge     = trial >= {1'b0, i_word.period};
        n_word = i_word;
        n_word.rem = ge ? diff[gcr_pkg::PER_W-1:0] : trial[gcr_pkg::PER_W-1:0];
        n_word.quo = {i_word.quo[gcr_pkg::QUO_W-2:0], ge};
    end

    assign o_ready = !r_valid || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
        if (o_ready && i_valid) begin
            r_word <= n_word;
        end
    end

    assign o_valid = r_valid;
    assign o_word  = r_word;

endmodule

`default_nettype wire

// ===== hw/rtl/gcr_telemetry_decoder.sv =====
// ----------------------------------------------------------------------------
// gcr_telemetry_decoder
// Bidirectional DShot GCR telemetry decoder with a pipelined eRPM divider.
// ----------------------------------------------------------------------------
// Takes one 21-bit received telemetry word per cycle while o_stall is low
// and returns one result word per input word, in order. The pipe is one
// decode stage (differential decode, inverse GCR lookup, nibble check and
// period expansion) followed by a chain of 26 divider cells, each producing
// one bit of eRPM = 60000000 / period. The last cell's register is the
// output register. Every stage holds its word while the stage after it is
// full and stalled, and takes a new word as soon as it empties, so gaps in the
// pipe close up while the output is stalled. Status: ok, invalid symbol
// (all other fields zero), CRC fail (payload only), zero period (payload and
// period code only). The start bit is not checked.
// ----------------------------------------------------------------------------
`default_nettype none

`include "gcr_telemetry_decoder_defines.svh"

module gcr_telemetry_decoder (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    // input word channel
    input  wire logic                          i_valid,
    input  wire logic [gcr_pkg::WIRE_W-1:0]    i_wire_word,
    output logic                               o_stall,
    // result word channel
    output logic                               o_valid,
    input  wire logic                          i_stall,
    output logic [1:0]                         o_status,
    output logic [gcr_pkg::PAY_W-1:0]          o_payload,
    output logic [gcr_pkg::CODE_W-1:0]         o_period_code,
    output logic [gcr_pkg::PER_W-1:0]          o_period,
    output logic [gcr_pkg::QUO_W-1:0]          o_erpm
);

    // Stage k feeds divider cell k; stage DIV_CELLS is the output register.
    logic               stg_valid [gcr_pkg::DIV_CELLS+1];
    logic               stg_ready [gcr_pkg::DIV_CELLS+1];
    gcr_pkg::t_div_word stg_word  [gcr_pkg::DIV_CELLS+1];
    logic               front_ready;

    gcr_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .i_wire_word (i_wire_word),
        .o_ready     (front_ready),
        .o_valid     (stg_valid[0]),
        .o_word      (stg_word[0]),
        .i_ready     (stg_ready[0])
    );

    // Cell k resolves quotient bit (QUO_W-1-k), most significant first.
    for (genvar k = 0; k < gcr_pkg::DIV_CELLS; k++) begin : g_cell
        gcr_div_cell u_cell (
            .i_clk     (i_clk),
            .i_rst_n   (i_rst_n),
            .i_num_bit (gcr_pkg::ERPM_NUM[5'(gcr_pkg::QUO_W-1-k)]),
            .i_valid   (stg_valid[k]),
            .i_word    (stg_word[k]),
            .o_ready   (stg_ready[k]),
            .o_valid   (stg_valid[k+1]),
            .o_word    (stg_word[k+1]),
            .i_ready   (stg_ready[k+1])
        );
    end

    // The downstream side drains the output register.
    assign stg_ready[gcr_pkg::DIV_CELLS] = !i_stall;
    assign o_stall                       = !front_ready;

    // Drive result fields from the last cell; eRPM is only meaningful when ok.
    assign o_valid       = stg_valid[gcr_pkg::DIV_CELLS];
    assign o_status      = stg_word[gcr_pkg::DIV_CELLS].status;
    assign o_payload     = stg_word[gcr_pkg::DIV_CELLS].payload;
    assign o_period_code = stg_word[gcr_pkg::DIV_CELLS].period_code;
    assign o_period      = stg_word[gcr_pkg::DIV_CELLS].period;
    assign o_erpm        = (stg_word[gcr_pkg::DIV_CELLS].status == gcr_pkg::ST_OK)
                         ? stg_word[gcr_pkg::DIV_CELLS].quo : '0;

    // An accepted input word lands in the decode stage.
    `GCR_ASSERT_NEXT(a_accept_lands, i_valid && !o_stall, stg_valid[0])
    // A good result always carries a nonzero period and eRPM.
    `GCR_ASSERT_SAME(a_ok_nonzero,
        o_valid && o_status == gcr_pkg::ST_OK, o_period != '0 && o_erpm != '0)
    // An invalid symbol clears every other field.
    `GCR_ASSERT_SAME(a_bad_symbol_zero,
        o_valid && o_status == gcr_pkg::ST_BAD_SYMBOL,
        o_payload == '0 && o_period_code == '0 && o_period == '0 && o_erpm == '0)
    // A zero period keeps the period code with a zero mantissa.
    `GCR_ASSERT_SAME(a_zero_period_code,
        o_valid && o_status == gcr_pkg::ST_ZERO_PERIOD,
        o_period_code[8:0] == '0 && o_period == '0 && o_erpm == '0)

endmodule

`default_nettype wire

// ===== verif/gcr_telemetry_decoder_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gcr_telemetry_decoder_tb
// Self-checking testbench for the GCR telemetry decoder.
// ----------------------------------------------------------------------------
// Drive 21-bit wire words into the decoder and predict each result word from
// an independent decode: differential decode, inverse GCR by search of the
// forward symbol table, nibble check, period expansion and eRPM division.
// Compare every result word field by field against the oldest prediction.
// Stimulus runs from a short directed set (extremes, every invalid symbol,
// check failures, zero periods) to random streams that are mostly well-formed
// words with random content, plus broken checks, bad symbols and raw noise.
// Both channels idle in random bursts but for one random segment and the end.
// ----------------------------------------------------------------------------

module gcr_telemetry_decoder_tb;

    // Pipe depth with no stalls: one decode stage plus one divider cell per
    // quotient bit.
    localparam int          LATENCY        = 27;
    localparam int unsigned ERPM_NUMERATOR = 60_000_000;
    localparam int unsigned DRAIN_LIMIT    = 20_000;

    // One predicted result word, tagged with the wire word that caused it.
    typedef struct {
        logic [gcr_pkg::WIRE_W-1:0] wire_word;
        gcr_pkg::t_status           status;
        logic [gcr_pkg::PAY_W-1:0]  payload;
        logic [gcr_pkg::CODE_W-1:0] period_code;
        logic [gcr_pkg::PER_W-1:0]  period;
        logic [gcr_pkg::QUO_W-1:0]  erpm;
    } t_telemetry_result;

    logic                        i_clk;
    logic                        i_rst_n;
    logic                        i_valid;
    logic [gcr_pkg::WIRE_W-1:0]  i_wire_word;
    logic                        o_stall;
    logic                        o_valid;
    logic                        i_stall;
    logic [1:0]                  o_status;
    logic [gcr_pkg::PAY_W-1:0]   o_payload;
    logic [gcr_pkg::CODE_W-1:0]  o_period_code;
    logic [gcr_pkg::PER_W-1:0]   o_period;
    logic [gcr_pkg::QUO_W-1:0]   o_erpm;

    t_telemetry_result   pending_results[$];
    int unsigned         mismatch_count = 0;
    bit                  idle_en        = 1'b1;

    gcr_telemetry_decoder dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .i_wire_word   (i_wire_word),
        .o_stall       (o_stall),
        .o_valid       (o_valid),
        .i_stall       (i_stall),
        .o_status      (o_status),
        .o_payload     (o_payload),
        .o_period_code (o_period_code),
        .o_period      (o_period),
        .o_erpm        (o_erpm)
    );

    // ------------------------------------------------------------------------
    // Clock and timeout
    // ------------------------------------------------------------------------
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Bound the run; a hung handshake ends here.
    initial begin
        #10_000_000;
        $display("timeout at %0t with %0d result words outstanding",
                 $time, pending_results.size());
        $display("*** FAILED ***");
        $finish;
    end

    // ------------------------------------------------------------------------
    // GCR coding helpers
    // ------------------------------------------------------------------------

    // Forward GCR table: nibble to 5-bit line symbol.
    function automatic logic [4:0] gcr_symbol(input logic [3:0] nib);
        logic [4:0] sym;
        case (nib)
            4'h0: sym = 5'h19;
            4'h1: sym = 5'h1B;
            4'h2: sym = 5'h12;
            4'h3: sym = 5'h13;
            4'h4: sym = 5'h1D;
            4'h5: sym = 5'h15;
            4'h6: sym = 5'h16;
            4'h7: sym = 5'h17;
            4'h8: sym = 5'h1A;
            4'h9: sym = 5'h09;
            4'hA: sym = 5'h0A;
            4'hB: sym = 5'h0B;
            4'hC: sym = 5'h1E;
            4'hD: sym = 5'h0D;
            4'hE: sym = 5'h0E;
            default: sym = 5'h0F;
        endcase
        return sym;
    endfunction

    // Invert by search of the forward table; bit 4 flags a legal symbol.
    function automatic logic [4:0] symbol_nibble(input logic [4:0] sym);
        int n;
        for (n = 0; n < 16; n++) begin
            if (gcr_symbol(4'(n)) == sym) return {1'b1, 4'(n)};
        end
        return 5'h00;
    endfunction

    // Return the n-th (0..15) symbol that is not in the table.
    function automatic logic [4:0] bad_symbol(input int unsigned which);
        int          s;
        int unsigned seen;
        logic [4:0]  looked_up;
        seen = 0;
        for (s = 0; s < 32; s++) begin
            looked_up = symbol_nibble(5'(s));
            if (!looked_up[4]) begin
                if (seen == which) return 5'(s);
                seen++;
            end
        end
        return 5'h00;
    endfunction

    function automatic logic [gcr_pkg::GCR_W-1:0] gcr_of_payload(
            input logic [gcr_pkg::PAY_W-1:0] pay);
        return {gcr_symbol(pay[15:12]), gcr_symbol(pay[11:8]),
                gcr_symbol(pay[7:4]), gcr_symbol(pay[3:0])};
    endfunction

    // Undo the differential decode: each wire bit is the GCR bit XOR the
    // wire bit above it, starting from the start bit.
    function automatic logic [gcr_pkg::WIRE_W-1:0] wire_of_gcr(
            input logic [gcr_pkg::GCR_W-1:0] gcr, input logic start_bit);
        logic [gcr_pkg::WIRE_W-1:0] w;
        int                         i;
        w     = '0;
        w[20] = start_bit;
        for (i = 19; i >= 0; i--) begin
            w[i] = gcr[i] ^ w[i+1];
        end
        return w;
    endfunction

    // Append the check nibble that makes all four nibbles XOR to 0xF.
    function automatic logic [gcr_pkg::PAY_W-1:0] payload_with_check(
            input logic [gcr_pkg::CODE_W-1:0] code);
        return {code, ~(code[11:8] ^ code[7:4] ^ code[3:0])};
    endfunction

    // ------------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------------
    function automatic t_telemetry_result decode_telemetry(
            input logic [gcr_pkg::WIRE_W-1:0] w);
        t_telemetry_result          r;
        logic [gcr_pkg::GCR_W-1:0]  gcr;
        logic [4:0]                 looked_up;
        logic [gcr_pkg::PAY_W-1:0]  pay;
        logic [gcr_pkg::PER_W-1:0]  per;
        int                         k;
        r.wire_word   = w;
        r.status      = gcr_pkg::ST_BAD_SYMBOL;
        r.payload     = '0;
        r.period_code = '0;
        r.period      = '0;
        r.erpm        = '0;
        gcr = w[19:0] ^ w[20:1];
        pay = '0;
        for (k = 0; k < 4; k++) begin
            looked_up = symbol_nibble(gcr[19-5*k -: 5]);
            if (!looked_up[4]) return r;
            pay = {pay[11:0], looked_up[3:0]};
        end
        r.payload = pay;
        if ((pay[15:12] ^ pay[11:8] ^ pay[7:4] ^ pay[3:0]) != 4'hF) begin
            r.status = gcr_pkg::ST_CRC_FAIL;
            return r;
        end
        r.period_code = pay[15:4];
        per = gcr_pkg::PER_W'({7'd0, pay[12:4]} << pay[15:13]);
        if (per == '0) begin
            r.status = gcr_pkg::ST_ZERO_PERIOD;
            return r;
        end
        r.status = gcr_pkg::ST_OK;
        r.period = per;
        r.erpm   = gcr_pkg::QUO_W'(ERPM_NUMERATOR / int'(per));
        return r;
    endfunction

    // Mostly well-formed words with random content; the rest broken checks,
    // bad symbols and raw noise.
    function automatic logic [gcr_pkg::WIRE_W-1:0] random_telemetry_word();
        logic [gcr_pkg::CODE_W-1:0] code;
        logic [gcr_pkg::PAY_W-1:0]  pay;
        logic [gcr_pkg::GCR_W-1:0]  gcr;
        int unsigned                kind;
        int unsigned                pos;
        code = gcr_pkg::CODE_W'($urandom);
        if ($urandom_range(0, 9) == 0) code[8:0] = '0;
        else if ($urandom_range(0, 9) == 0) code[8:0] = 9'($urandom_range(1, 3));
        pay  = payload_with_check(code);
        kind = $urandom_range(0, 99);
        if (kind < 10) return gcr_pkg::WIRE_W'($urandom);
        if (kind < 20) begin
            pos = $urandom_range(0, 3);
            pay = pay ^ (gcr_pkg::PAY_W'($urandom_range(1, 15)) << (4 * pos));
        end
        gcr = gcr_of_payload(pay);
        if (kind >= 20 && kind < 30) begin
            pos = $urandom_range(0, 3);
            gcr[19-5*pos -: 5] = bad_symbol($urandom_range(0, 15));
        end
        return wire_of_gcr(gcr, 1'($urandom));
    endfunction

    // ------------------------------------------------------------------------
    // Input channel
    // ------------------------------------------------------------------------

    // Hold the word until the decoder takes it, then log its prediction.
    // Leave i_valid high on return; the caller drops it when the stream stops.
    task automatic send_word(input logic [gcr_pkg::WIRE_W-1:0] w);
        if (idle_en && $urandom_range(0, 3) == 0) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 15)) @(posedge i_clk);
        end
        i_valid     <= 1'b1;
        i_wire_word <= w;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        pending_results.push_back(decode_telemetry(w));
    endtask

    // Wait for every outstanding result word; flag any that never shows up.
    task automatic wait_for_drain();
        int unsigned cycles;
        cycles = 0;
        while (pending_results.size() != 0 && cycles < DRAIN_LIMIT) begin
            @(posedge i_clk);
            cycles++;
        end
        if (pending_results.size() != 0) begin
            $display("%0t: %0d result words never arrived, oldest from wire word %h",
                     $time, pending_results.size(), pending_results[0].wire_word);
            mismatch_count += pending_results.size();
            pending_results.delete();
        end
    endtask

    // ------------------------------------------------------------------------
    // Output channel: random stall bursts, off in the unthrottled stretch
    // ------------------------------------------------------------------------
    initial begin
        i_stall <= 1'b0;
        forever begin
            repeat ($urandom_range(1, 20)) @(posedge i_clk);
            if (idle_en && $urandom_range(0, 1) == 0) begin
                i_stall <= 1'b1;
                repeat ($urandom_range(1, 15)) @(posedge i_clk);
                i_stall <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Result checking
    // ------------------------------------------------------------------------
    task automatic check_field(input string name,
                               input logic [gcr_pkg::WIRE_W-1:0] w,
                               input longint unsigned want, input longint unsigned got);
        if (want != got) begin
            $display("%0t: %s mismatch for wire word %h, expected %0h, actual %0h",
                     $time, name, w, want, got);
            mismatch_count++;
        end
    endtask

    // Sample at the edge: a word moves when o_valid is high and i_stall low.
    always @(posedge i_clk) begin : result_check
        t_telemetry_result want;
        if (i_rst_n && o_valid && !i_stall) begin
            if (pending_results.size() == 0) begin
                $display("%0t: unexpected result word, status %0d payload %h",
                         $time, o_status, o_payload);
                mismatch_count++;
            end else begin
                want = pending_results.pop_front();
                check_field("status",      want.wire_word, want.status,      o_status);
                check_field("payload",     want.wire_word, want.payload,     o_payload);
                check_field("period_code", want.wire_word, want.period_code, o_period_code);
                check_field("period",      want.wire_word, want.period,      o_period);
                check_field("erpm",        want.wire_word, want.erpm,        o_erpm);
            end
        end
    end

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------

    // Extremes, boundary periods, check failure and every bad symbol.
    task automatic test_directed();
        logic [gcr_pkg::GCR_W-1:0] gcr;
        int unsigned               i;
        // all-zero and all-one wire words both decode to illegal symbols
        send_word('0);
        send_word('1);
        // shortest period (1 us, full-scale eRPM) with either start bit
        send_word(wire_of_gcr(gcr_of_payload(payload_with_check(12'h001)), 1'b1));
        send_word(wire_of_gcr(gcr_of_payload(payload_with_check(12'h001)), 1'b0));
        // longest period: full mantissa, top exponent
        send_word(wire_of_gcr(gcr_of_payload(payload_with_check(12'hFFF)), 1'b1));
        // zero mantissa at the lowest and a middle exponent
        send_word(wire_of_gcr(gcr_of_payload(payload_with_check(12'h000)), 1'b0));
        send_word(wire_of_gcr(gcr_of_payload(payload_with_check(12'hA00)), 1'b1));
        // legal symbols with a broken check nibble
        send_word(wire_of_gcr(gcr_of_payload(payload_with_check(12'h123) ^ 16'h0001), 1'b1));
        // each illegal symbol, rotating through the four symbol slots
        for (i = 0; i < 16; i++) begin
            gcr = gcr_of_payload(payload_with_check(gcr_pkg::CODE_W'($urandom)));
            gcr[19-5*(i%4) -: 5] = bad_symbol(i);
            send_word(wire_of_gcr(gcr, i[0]));
        end
        // full mantissa at the lowest exponent
        send_word(wire_of_gcr(gcr_of_payload(payload_with_check(12'h1FF)), 1'b0));
    endtask

    // Long random stream; one segment runs with both sides idling switched off.
    task automatic test_random_stream();
        int seg;
        int n;
        for (seg = 0; seg < 10; seg++) begin
            idle_en = (seg != 4);
            for (n = 0; n < 100; n++) send_word(random_telemetry_word());
        end
        idle_en = 1'b1;
    endtask

    // Stop sending until the pipe has emptied, several times over.
    task automatic test_drain_pause();
        int batch;
        int n;
        for (batch = 0; batch < 4; batch++) begin
            for (n = 0; n < 50; n++) send_word(random_telemetry_word());
            i_valid <= 1'b0;
            wait_for_drain();
        end
    endtask

    // Final stretch at full rate: no sender gaps, no receiver stalls.
    task automatic test_unthrottled();
        int n;
        idle_en = 1'b0;
        for (n = 0; n < 300; n++) send_word(random_telemetry_word());
        i_valid <= 1'b0;
    endtask

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial begin
        i_rst_n     <= 1'b0;
        i_valid     <= 1'b0;
        i_wire_word <= '0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_directed();
        test_random_stream();
        test_drain_pause();
        test_unthrottled();

        // drain, then watch a little longer for stray result words
        wait_for_drain();
        repeat (LATENCY + 13) @(posedge i_clk);

        if (mismatch_count == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
